[rtl/palette_index_pixel_unpacker_top_defines.svh]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker assertion macros
// Shared macros for the concurrent assertions of the unpacker checker.
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEX_PIXEL_UNPACKER_TOP_DEFINES_SVH
`define PALETTE_INDEX_PIXEL_UNPACKER_TOP_DEFINES_SVH

// Holds at every edge outside reset: pre overlapping with post.
`define PIPU_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// When pre holds, post holds at the following edge.
`define PIPU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/pipu_pkg.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker package
// Constants, codes and control structs shared by the unpacker modules.
// ----------------------------------------------------------------------------
package pipu_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] PALETTE_LIMIT = 9'(PALETTE_ENTRIES);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_CODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = 1'd1;

   localparam logic [2:0] WCODE_ZERO  = 3'd0;
   localparam logic [2:0] WCODE_ONE   = 3'd1;
   localparam logic [2:0] WCODE_TWO   = 3'd2;
   localparam logic [2:0] WCODE_FOUR  = 3'd3;
   localparam logic [2:0] WCODE_EIGHT = 3'd4;

   localparam logic OP_LOAD_ENTRY  = 1'b0;
   localparam logic OP_PACKED_BYTE = 1'b1;

   localparam logic [24:0] MAX_FRAME        = 25'd16777216;
   localparam logic [24:0] RESET_FRAME_LAST = 25'd65535;

   typedef struct packed {
      logic write_entry;
      logic load_byte;
      logic issue;
   } pipu_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_pixel;
   } pipu_status_type;

endpackage

[rtl/pipu_ctrl.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker controller
// Accepts items and sequences the pixels of one packed byte.
// ----------------------------------------------------------------------------
module pipu_ctrl
   import pipu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_opcode,
   output logic            req_ready,
   input  pipu_status_type status,
   output pipu_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UNPACK = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      issue;
   logic      accept;

   always_comb begin
      issue       = (state_ff == ST_UNPACK) && status.out_free;
      req_ready   = (state_ff == ST_IDLE) || (issue && status.last_pixel);
      accept      = req_valid && req_ready;
      cmd.issue       = issue;
      cmd.write_entry = accept && (req_opcode == OP_LOAD_ENTRY);
      cmd.load_byte   = accept && (req_opcode == OP_PACKED_BYTE);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_byte) state_in = ST_UNPACK;
         end
         ST_UNPACK: begin
            if (cmd.load_byte) state_in = ST_UNPACK;
            else if (issue && status.last_pixel) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

[rtl/pipu_datapath.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker datapath
// Palette memory, index extraction, pixel counter and result register.
// ----------------------------------------------------------------------------
module pipu_datapath
   import pipu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [7:0]             req_entry_index,
   input  logic [7:0]             req_entry_red,
   input  logic [7:0]             req_entry_green,
   input  logic [7:0]             req_entry_blue,
   input  logic [7:0]             req_packed_byte,
   input  pipu_cmd_type           cmd,
   output pipu_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_pixel_red,
   output logic [7:0]             rsp_pixel_green,
   output logic [7:0]             rsp_pixel_blue,
   output logic [7:0]             rsp_pixel_index,
   output logic                   rsp_last_of_byte,
   output logic                   rsp_end_of_frame
);

   logic [23:0]           pal_mem [PALETTE_ENTRIES];
   logic                  pal_valid_ff [PALETTE_ENTRIES];

   logic [2:0]            cfg_code_ff, cfg_code_in;
   logic [24:0]           frame_last_ff, frame_last_in;
   logic [24:0]           pixel_count_ff, pixel_count_in;
   logic [7:0]            byte_ff, byte_in;
   logic [2:0]            code_ff, code_in;
   logic [3:0]            remain_ff, remain_in;
   logic                  out_valid_ff, out_valid_in;
   logic [23:0]           color_ff;
   logic                  color_ok_ff;
   logic [7:0]            index_ff;
   logic                  last_ff;
   logic                  eof_ff;

   logic [7:0]            cur_index;
   logic [7:0]            shifted;
   logic [3:0]            byte_count;
   logic                  eof;
   logic                  last_pixel;
   logic                  index_ok;
   logic                  entry_ok;
   logic [PAL_ADDR_W-1:0] rd_addr;
   logic [PAL_ADDR_W-1:0] wr_addr;

   always_comb begin
      case (code_ff)
         WCODE_ZERO: begin
            cur_index = 8'd0;
            shifted   = byte_ff;
         end
         WCODE_ONE: begin
            cur_index = {7'd0, byte_ff[0]};
            shifted   = {1'b0, byte_ff[7:1]};
         end
         WCODE_TWO: begin
            cur_index = {6'd0, byte_ff[1:0]};
            shifted   = {2'b0, byte_ff[7:2]};
         end
         WCODE_FOUR: begin
            cur_index = {4'd0, byte_ff[3:0]};
            shifted   = {4'b0, byte_ff[7:4]};
         end
         default: begin
            cur_index = byte_ff;
            shifted   = 8'd0;
         end
      endcase
      case (cfg_code_ff)
         WCODE_ZERO: byte_count = 4'd8;
         WCODE_ONE:  byte_count = 4'd8;
         WCODE_TWO:  byte_count = 4'd4;
         WCODE_FOUR: byte_count = 4'd2;
         default:    byte_count = 4'd1;
      endcase
   end

   always_comb begin
      eof        = pixel_count_ff >= frame_last_ff;
      last_pixel = (remain_ff == 4'd1) || eof;
      index_ok   = {1'b0, cur_index} < PALETTE_LIMIT;
      entry_ok   = {1'b0, req_entry_index} < PALETTE_LIMIT;
      rd_addr    = cur_index[PAL_ADDR_W-1:0];
      wr_addr    = req_entry_index[PAL_ADDR_W-1:0];
      status.out_free   = !out_valid_ff || rsp_ready;
      status.last_pixel = last_pixel;
   end

   always_comb begin
      cfg_code_in   = cfg_code_ff;
      frame_last_in = frame_last_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH_CODE: begin
               cfg_code_in = csr_write_data[2:0];
            end
            CSR_FRAME_COUNT: begin
               if (csr_write_data == 25'd0) frame_last_in = 25'd0;
               else if (csr_write_data > MAX_FRAME) frame_last_in = MAX_FRAME - 25'd1;
               else frame_last_in = csr_write_data - 25'd1;
            end
            default: begin
               cfg_code_in = cfg_code_ff;
            end
         endcase
      end
   end

   always_comb begin
      pixel_count_in = pixel_count_ff;
      byte_in        = byte_ff;
      code_in        = code_ff;
      remain_in      = remain_ff;
      out_valid_in   = out_valid_ff;
      if (cmd.issue) begin
         pixel_count_in = eof ? 25'd0 : pixel_count_ff + 25'd1;
         byte_in        = shifted;
         remain_in      = eof ? 4'd0 : remain_ff - 4'd1;
         out_valid_in   = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_byte) begin
         byte_in   = req_packed_byte;
         code_in   = cfg_code_ff;
         remain_in = byte_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_code_ff    <= WCODE_EIGHT;
         frame_last_ff  <= RESET_FRAME_LAST;
         pixel_count_ff <= 25'd0;
         remain_ff      <= 4'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         cfg_code_ff    <= cfg_code_in;
         frame_last_ff  <= frame_last_in;
         pixel_count_ff <= pixel_count_in;
         remain_ff      <= remain_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      code_ff <= code_in;
   end

   // Entries that were never loaded read as zero through their valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) pal_valid_ff[i] <= 1'b0;
      end else if (cmd.write_entry && entry_ok) begin
         pal_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && entry_ok) begin
         pal_mem[wr_addr] <= {req_entry_red, req_entry_green, req_entry_blue};
      end
      if (cmd.issue) begin
         color_ff    <= pal_mem[rd_addr];
         color_ok_ff <= index_ok && pal_valid_ff[rd_addr];
         index_ff    <= cur_index;
         last_ff     <= last_pixel;
         eof_ff      <= eof;
      end
   end

   always_comb begin
      rsp_valid        = out_valid_ff;
      rsp_pixel_red    = color_ok_ff ? color_ff[23:16] : 8'd0;
      rsp_pixel_green  = color_ok_ff ? color_ff[15:8] : 8'd0;
      rsp_pixel_blue   = color_ok_ff ? color_ff[7:0] : 8'd0;
      rsp_pixel_index  = index_ff;
      rsp_last_of_byte = last_ff;
      rsp_end_of_frame = eof_ff;
   end

endmodule

[rtl/palette_index_pixel_unpacker_top.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker
// Expands packed palette indices into RGB pixels through a colour table.
// ----------------------------------------------------------------------------
// The req channel carries one item per handshake: either a palette entry load
// or one packed byte of indices, cut from the lowest bits upward. The rsp
// channel gives one pixel item per index until the frame ends, with its
// colour, its index, and flags for the last pixel of the byte and of the frame.
// The csr port writes the index width code and the frame pixel count; write
// it only while the block is idle.
// A palette load gives no result. A byte is first registered; then the block
// looks up each pixel through the single read port of the palette memory
// and issues one pixel per cycle into the result register while the
// receiver does not stall. A byte gives eight pixels in the one-bit and
// zero-bit modes, four, two or one otherwise, fewer if the frame ends inside
// it. The next item is taken in the cycle the last pixel of a byte is issued.
// When the receiver stalls, the result register holds its pixel and the
// unpacker waits with the next one. Reset clears the palette at once through
// per-entry valid bits, restores the register defaults and zeroes the counter.
// ----------------------------------------------------------------------------
module palette_index_pixel_unpacker_top
   import pipu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [7:0]             req_entry_index,
   input  logic [7:0]             req_entry_red,
   input  logic [7:0]             req_entry_green,
   input  logic [7:0]             req_entry_blue,
   input  logic [7:0]             req_packed_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_pixel_red,
   output logic [7:0]             rsp_pixel_green,
   output logic [7:0]             rsp_pixel_blue,
   output logic [7:0]             rsp_pixel_index,
   output logic                   rsp_last_of_byte,
   output logic                   rsp_end_of_frame
);

   pipu_cmd_type    cmd;
   pipu_status_type status;

   pipu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pipu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_entry_index  (req_entry_index),
      .req_entry_red    (req_entry_red),
      .req_entry_green  (req_entry_green),
      .req_entry_blue   (req_entry_blue),
      .req_packed_byte  (req_packed_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_red    (rsp_pixel_red),
      .rsp_pixel_green  (rsp_pixel_green),
      .rsp_pixel_blue   (rsp_pixel_blue),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

[rtl/pipu_checker.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker checker
// Port-level assertions on the unpacker, bound to the top level.
// ----------------------------------------------------------------------------
`include "palette_index_pixel_unpacker_top_defines.svh"

module pipu_checker
   import pipu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_write_data,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_opcode,
   input logic [7:0]             req_entry_index,
   input logic [7:0]             req_entry_red,
   input logic [7:0]             req_entry_green,
   input logic [7:0]             req_entry_blue,
   input logic [7:0]             req_packed_byte,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [7:0]             rsp_pixel_red,
   input logic [7:0]             rsp_pixel_green,
   input logic [7:0]             rsp_pixel_blue,
   input logic [7:0]             rsp_pixel_index,
   input logic                   rsp_last_of_byte,
   input logic                   rsp_end_of_frame
);

   `PIPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
   `PIPU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_pixel_index) && $stable(rsp_pixel_red), "rsp item changed while stalled")
   `PIPU_ASSERT_SAME(a_eof_ends_byte, clock, reset, rsp_valid && rsp_end_of_frame, rsp_last_of_byte, "frame end without end of byte")
   `PIPU_ASSERT_NEXT(a_busy_emits, clock, reset, !req_ready && !rsp_valid, rsp_valid, "unpacker busy without issuing a pixel")

endmodule

bind palette_index_pixel_unpacker_top pipu_checker u_pipu_checker (.*);

[sim/tb_palette_index_pixel_unpacker_top.sv]
// ----------------------------------------------------------------------------
// Palette index pixel unpacker testbench
// Drives palette loads and packed bytes through the request channel. Register
// settings change between phases while the block is idle. Every pixel on the
// response channel is checked against a local model of the colour table and
// the frame counter. A directed opening covers the corner cases, then a long
// receiver stall, and random phases follow with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_palette_index_pixel_unpacker_top;
   import pipu_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 200;
   localparam int RANDOM_ITEMS   = 290;

   typedef struct packed {
      logic       opcode;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] packed_byte;
   } request_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] index;
      logic       last_of_byte;
      logic       end_of_frame;
   } pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_opcode = OP_LOAD_ENTRY;
   logic [7:0]             req_entry_index = '0;
   logic [7:0]             req_entry_red = '0;
   logic [7:0]             req_entry_green = '0;
   logic [7:0]             req_entry_blue = '0;
   logic [7:0]             req_packed_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_pixel_red;
   logic [7:0]             rsp_pixel_green;
   logic [7:0]             rsp_pixel_blue;
   logic [7:0]             rsp_pixel_index;
   logic                   rsp_last_of_byte;
   logic                   rsp_end_of_frame;

   // Local copy of the block state.
   logic [23:0] palette_shadow [PALETTE_ENTRIES];
   logic [24:0] pixel_position = '0;
   logic [2:0]  width_code = WCODE_EIGHT;
   logic [24:0] frame_count = 25'd65536;

   request_type pending_requests [$];
   pixel_type   expected_pixels [$];

   logic req_fire = 1'b0;
   logic gaps_on = 1'b0;
   logic hold_request = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   int   idle_cycles = 0;
   int   mismatch_count = 0;
   int   loads_accepted = 0;
   int   bytes_accepted = 0;
   int   pixels_checked = 0;
   int   settings_applied = 0;

   palette_index_pixel_unpacker_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_entry_index  (req_entry_index),
      .req_entry_red    (req_entry_red),
      .req_entry_green  (req_entry_green),
      .req_entry_blue   (req_entry_blue),
      .req_packed_byte  (req_packed_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_red    (rsp_pixel_red),
      .rsp_pixel_green  (rsp_pixel_green),
      .rsp_pixel_blue   (rsp_pixel_blue),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 7) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [24:0] random_frame();
      case ($urandom_range(0, 9))
         0: return 25'd0;
         1: return 25'd1;
         2: return MAX_FRAME;
         3: return 25'h1FFFFFF;
         4: return 25'd65536;
         5, 6: return 25'($urandom_range(2, 300));
         default: return 25'($urandom_range(2, 40));
      endcase
   endfunction

   // Cuts one packed byte into indices and queues the pixels it should give.
   task automatic unpack_byte(input logic [7:0] packed_value);
      int          bits;
      int          count;
      logic [24:0] frame;
      logic [7:0]  index;
      logic [23:0] colour;
      logic        frame_done;
      case (width_code)
         WCODE_ZERO: bits = 0;
         WCODE_ONE:  bits = 1;
         WCODE_TWO:  bits = 2;
         WCODE_FOUR: bits = 4;
         default:    bits = 8;
      endcase
      count = (bits == 0) ? 8 : 8 / bits;
      if (frame_count == 25'd0) begin
         frame = 25'd1;
      end else if (frame_count > MAX_FRAME) begin
         frame = MAX_FRAME;
      end else begin
         frame = frame_count;
      end
      for (int i = 0; i < count; i++) begin
         index = (bits == 0) ? 8'd0 : 8'((int'(packed_value) >> (i * bits)) & ((1 << bits) - 1));
         colour = (int'(index) < PALETTE_ENTRIES) ? palette_shadow[index] : 24'd0;
         frame_done = ({1'b0, pixel_position} + 26'd1) >= {1'b0, frame};
         expected_pixels.push_back({colour[23:16], colour[15:8], colour[7:0], index,
                                    frame_done || (i == count - 1), frame_done});
         if (frame_done) begin
            pixel_position = '0;
            break;
         end
         pixel_position = pixel_position + 25'd1;
      end
   endtask

   task automatic push_load(input logic [7:0] entry, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
      pending_requests.push_back({OP_LOAD_ENTRY, entry, red, green, blue, 8'($urandom)});
   endtask

   task automatic push_byte(input logic [7:0] packed_value);
      pending_requests.push_back({OP_PACKED_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), packed_value});
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      if (index == CSR_WIDTH_CODE) begin
         width_code = data[2:0];
      end else begin
         frame_count = data[24:0];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] code, input logic [24:0] frame);
      wait_drained();
      write_reg(CSR_WIDTH_CODE, CSR_DATA_W'(code));
      write_reg(CSR_FRAME_COUNT, CSR_DATA_W'(frame));
      settings_applied++;
      @(posedge clock);
   endtask

   // Request driver: holds each item until it is taken, then idles at random.
   always @(negedge clock) begin : request_driver
      request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_opcode <= item.opcode;
            req_entry_index <= item.entry_index;
            req_entry_red <= item.red;
            req_entry_green <= item.green;
            req_entry_blue <= item.blue;
            req_packed_byte <= item.packed_byte;
            req_valid <= 1'b1;
            req_gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus one long hold when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_hold = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : pixel_monitor
      pixel_type seen;
      pixel_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         if (req_opcode == OP_LOAD_ENTRY) begin
            palette_shadow[req_entry_index] = {req_entry_red, req_entry_green, req_entry_blue};
            loads_accepted++;
         end else begin
            unpack_byte(req_packed_byte);
            bytes_accepted++;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_pixel_red, rsp_pixel_green, rsp_pixel_blue, rsp_pixel_index,
                 rsp_last_of_byte, rsp_end_of_frame};
         if (expected_pixels.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected pixel: rgb %02h%02h%02h index %02h last %b eof %b",
                        seen.red, seen.green, seen.blue, seen.index, seen.last_of_byte,
                        seen.end_of_frame);
            end
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (seen !== want) begin
               if (mismatch_count < 10) begin
                  $display("pixel %0d: expected rgb %02h%02h%02h index %02h last %b eof %b",
                           pixels_checked, want.red, want.green, want.blue, want.index,
                           want.last_of_byte, want.end_of_frame);
                  $display("pixel %0d:      got rgb %02h%02h%02h index %02h last %b eof %b",
                           pixels_checked, seen.red, seen.green, seen.blue, seen.index,
                           seen.last_of_byte, seen.end_of_frame);
               end
               mismatch_count++;
            end
            pixels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_items;
      int phase_items;
      random_items = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         palette_shadow[i] = 24'd0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: eight-bit indices against a cleared table, then loads.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_load(8'd0, 8'hFF, 8'hFF, 8'hFF);
      push_load(8'd255, 8'hA5, 8'h5A, 8'hC3);
      push_load(8'd1, 8'h01, 8'h02, 8'h03);
      push_load(8'd2, 8'h80, 8'h40, 8'h20);
      push_load(8'd3, 8'h7F, 8'hFE, 8'h10);
      push_load(8'd15, 8'h0F, 8'hF0, 8'hAA);
      push_byte(8'hFF);
      push_byte(8'h00);
      // A frame that ends inside a byte drops the rest of that byte.
      configure(WCODE_ONE, 25'd5);
      push_byte(8'hA5);
      push_byte(8'h3C);
      configure(WCODE_ZERO, 25'd65536);
      push_byte(8'h5A);
      configure(WCODE_TWO, 25'd65536);
      push_byte(8'hE4);
      configure(WCODE_FOUR, 25'd65536);
      push_byte(8'hF0);
      // A zero frame size behaves as one pixel per frame.
      configure(3'd7, 25'd0);
      push_byte(8'h01);
      push_byte(8'hFF);
      configure(3'd5, MAX_FRAME);
      push_byte(8'h03);
      configure(3'd6, MAX_FRAME);
      push_byte(8'h02);
      // Shrinking the frame below the counter ends the frame on the next pixel.
      configure(WCODE_ONE, 25'd1000);
      push_byte(8'h55);
      push_byte(8'hAA);
      configure(WCODE_ONE, 25'd3);
      push_byte(8'h0F);
      configure(WCODE_EIGHT, 25'h1FFFFFF);
      push_byte(8'hC3);

      // Long receiver stall with the sender pushing one-bit bytes back to back.
      configure(WCODE_ONE, 25'd1000);
      gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (24) begin
         push_byte(8'($urandom));
         random_items++;
      end

      while (random_items < RANDOM_ITEMS) begin
         configure(3'($urandom_range(0, 7)), random_frame());
         gaps_on = ($urandom_range(0, 3) != 0);
         phase_items = $urandom_range(10, 40);
         repeat (phase_items) begin
            if ($urandom_range(0, 99) < 30) begin
               push_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               push_byte(8'($urandom));
            end
            random_items++;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d palette loads and %0d packed bytes, %0d pixels checked.",
               loads_accepted, bytes_accepted, pixels_checked);
      $display("Used %0d register settings: all width codes, frame sizes from 0 to the top.",
               settings_applied);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d pixels missing", mismatch_count, expected_pixels.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
